@@ rtl/wpvc_pkg.sv @@
// Shared types and constants for the wall particle velocity correction core.
// No dependencies; used by every other file in rtl/.
`default_nettype none

package wpvc_pkg;

  localparam int unsigned SQ_STEPS  = 32;  // one root bit per stage
  localparam int unsigned DIV_STEPS = 17;  // quotient magnitude never exceeds 1.0

  localparam logic [1:0] MODE_ESCAPE  = 2'd0;
  localparam logic [1:0] MODE_STICK   = 2'd1;
  localparam logic [1:0] MODE_REBOUND = 2'd2;

  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_RESTITUTION = 2'd1;
  localparam logic [1:0] REG_FRICTION    = 2'd2;

  localparam logic [18:0] Q_ONE = 19'd65536;

  typedef struct packed {
    logic            wall;
    logic [2:0][31:0] area;
    logic [2:0][31:0] vel;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/wall_particle_velocity_correct_core.sv @@
// Top level of the wall particle velocity correction core.
// Depends on wpvc_pkg, wpvc_sqrt and wpvc_div.
`default_nettype none

// Each transfer on the input stream describes one particle that hit a boundary
// face; exactly one transfer leaves on the output stream for it, in order.
// The core is a single pipeline that accepts one item every clock cycle and
// holds its whole contents when the output is stalled (in_tready is low
// exactly while a finished result waits and out_tready is low). An item
// passes through the input register, the stages that square and sum the face
// area vector, the bit-per-stage square root that gives the face area
// magnitude, the three parallel dividers that form the unit normal, a
// register that applies its sign, multiply stages for the normal speed, the
// restitution term and the friction term, and the output register, where the
// result is saturated to Q16.16. Non-wall faces and the escape and stick
// modes travel down the same pipeline and are selected at the output.
// Configuration (mode, restitution, friction) is written through cfg_we,
// cfg_index and cfg_data and is read by the stages that use it as each item
// passes them; it may only change while the pipeline is empty. A mode value
// of 3 acts as rebound.
module wall_particle_velocity_correct_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // area_x, area_y, area_z, vel_x, vel_y, vel_z from bit 0 up
  input  wire logic [191:0] in_tdata,
  // is_wall
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // new_vel_x, new_vel_y, new_vel_z from bit 0 up
  output logic      [95:0]  out_tdata,
  // handled, keep_particle from bit 0 up
  output logic      [1:0]   out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [17:0]  cfg_data
);

  localparam int unsigned QLAT = wpvc_pkg::DIV_STEPS;
  localparam int unsigned SLAT = wpvc_pkg::SQ_STEPS;

  // Configuration registers.
  logic [1:0]  mode_r;
  logic [17:0] rest_r;
  logic [16:0] fric_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= wpvc_pkg::MODE_REBOUND;
      rest_r <= 18'd65536;
      fric_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wpvc_pkg::REG_MODE:        mode_r <= cfg_data[1:0];
        wpvc_pkg::REG_RESTITUTION: rest_r <= cfg_data;
        wpvc_pkg::REG_FRICTION:    fric_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together; it holds only when the output
  // register is full and not being taken.
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Input register.
  logic            v0_r;
  wpvc_pkg::item_t p0_r;
  // Squares of the area components.
  logic            v1_r;
  wpvc_pkg::item_t p1_r;
  logic [2:0][63:0] sq_r;
  // Sum of squares.
  logic            v2_r;
  wpvc_pkg::item_t p2_r;
  logic [63:0]     a2_r;
  // Delay alongside the square root.
  logic            vs_r [0:SLAT-1];
  wpvc_pkg::item_t ps_r [0:SLAT-1];
  logic [31:0]     len;
  // Delay alongside the dividers.
  logic            vq_r [0:QLAT-1];
  wpvc_pkg::item_t pq_r [0:QLAT-1];
  logic            lz_r [0:QLAT-1];
  logic [2:0][16:0] quo;
  // Signed unit normal.
  logic            vn_r;
  wpvc_pkg::item_t pn_r;
  logic signed [17:0] n_r [0:2];
  // Velocity times normal.
  logic            va_r;
  wpvc_pkg::item_t pa_r;
  logic signed [17:0] na_r [0:2];
  logic signed [49:0] prod_r [0:2];
  // Normal speed.
  logic            vb_r;
  wpvc_pkg::item_t pb_r;
  logic signed [17:0] nb_r [0:2];
  logic signed [35:0] un_r;
  // Normal part and scaled normal speed.
  logic            vc_r;
  wpvc_pkg::item_t pc_r;
  logic signed [17:0] nc_r [0:2];
  logic signed [53:0] t_r [0:2];
  logic signed [55:0] sraw_r;
  logic            posc_r;
  // Tangential part.
  logic            vd_r;
  wpvc_pkg::item_t pd_r;
  logic signed [17:0] nd_r [0:2];
  logic signed [38:0] ut_r [0:2];
  logic signed [39:0] s_r;
  logic            posd_r;
  // Friction and restitution products.
  logic            ve_r;
  wpvc_pkg::item_t pe_r;
  logic signed [56:0] f_r [0:2];
  logic signed [57:0] nr_r [0:2];
  // Output register.
  logic [95:0]     out_data_r;
  logic [1:0]      out_user_r;

  wpvc_pkg::item_t in_item;
  assign in_item.wall = in_tuser[0];
  assign in_item.area = in_tdata[95:0];
  assign in_item.vel  = in_tdata[191:96];

  // Magnitudes of the area components, both for squaring and for the
  // dividers at the far end of the square root.
  logic [2:0][31:0] mag0;
  logic [2:0][31:0] magq;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag0[i] = p0_r.area[i][31] ? 32'(-p0_r.area[i]) : p0_r.area[i];
      magq[i] = ps_r[SLAT-1].area[i][31] ? 32'(-ps_r[SLAT-1].area[i])
                                         : ps_r[SLAT-1].area[i];
    end
  end

  wpvc_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .val_i  (a2_r),
    .root_o (len)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    wpvc_div u_div (
      .clk   (clk),
      .en    (en),
      .num_i ({magq[g], 16'h0000}),
      .den_i (len),
      .quo_o (quo[g])
    );
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int k = 0; k < SLAT; k++) vs_r[k] <= 1'b0;
      for (int k = 0; k < QLAT; k++) vq_r[k] <= 1'b0;
      vn_r <= 1'b0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      vs_r[0] <= v2_r;
      for (int k = 1; k < SLAT; k++) vs_r[k] <= vs_r[k-1];
      vq_r[0] <= vs_r[SLAT-1];
      for (int k = 1; k < QLAT; k++) vq_r[k] <= vq_r[k-1];
      vn_r <= vq_r[QLAT-1];
      va_r <= vn_r;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      out_valid_r <= ve_r;
    end
  end

  // Rebound arithmetic of the last stages.
  logic signed [51:0] dot;
  logic signed [43:0] res [0:2];
  logic [95:0]        reb_data;
  always_comb begin
    dot = 52'(prod_r[0]) + 52'(prod_r[1]) + 52'(prod_r[2]);
    for (int i = 0; i < 3; i++) begin
      res[i] = 44'($signed(pe_r.vel[i])) - 44'($signed(nr_r[i][57:16]))
             - 44'($signed(f_r[i][56:16]));
      if (res[i] > 44'sd2147483647) begin
        reb_data[32*i +: 32] = 32'h7FFF_FFFF;
      end else if (res[i] < -44'sd2147483648) begin
        reb_data[32*i +: 32] = 32'h8000_0000;
      end else begin
        reb_data[32*i +: 32] = res[i][31:0];
      end
    end
  end

  // Data registers, no reset needed.
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= in_item;

      p1_r <= p0_r;
      for (int i = 0; i < 3; i++) sq_r[i] <= 64'(mag0[i]) * 64'(mag0[i]);

      p2_r <= p1_r;
      a2_r <= sq_r[0] + sq_r[1] + sq_r[2];

      ps_r[0] <= p2_r;
      for (int k = 1; k < SLAT; k++) ps_r[k] <= ps_r[k-1];

      pq_r[0] <= ps_r[SLAT-1];
      lz_r[0] <= (len == 32'd0);
      for (int k = 1; k < QLAT; k++) begin
        pq_r[k] <= pq_r[k-1];
        lz_r[k] <= lz_r[k-1];
      end

      // A zero-length area vector has no normal at all.
      pn_r <= pq_r[QLAT-1];
      for (int i = 0; i < 3; i++) begin
        if (lz_r[QLAT-1]) begin
          n_r[i] <= '0;
        end else if (pq_r[QLAT-1].area[i][31]) begin
          n_r[i] <= -$signed({1'b0, quo[i]});
        end else begin
          n_r[i] <= $signed({1'b0, quo[i]});
        end
      end

      pa_r <= pn_r;
      for (int i = 0; i < 3; i++) begin
        na_r[i]   <= n_r[i];
        prod_r[i] <= 50'($signed(pn_r.vel[i])) * 50'(n_r[i]);
      end

      pb_r <= pa_r;
      nb_r <= na_r;
      un_r <= dot[51:16];

      pc_r <= pb_r;
      nc_r <= nb_r;
      for (int i = 0; i < 3; i++) t_r[i] <= 54'(un_r) * 54'(nb_r[i]);
      sraw_r <= 56'($signed({1'b0, wpvc_pkg::Q_ONE + 19'(rest_r)})) * 56'(un_r);
      posc_r <= !un_r[35] && (un_r != '0);

      pd_r <= pc_r;
      nd_r <= nc_r;
      for (int i = 0; i < 3; i++) begin
        ut_r[i] <= 39'($signed(pc_r.vel[i])) - 39'($signed(t_r[i][53:16]));
      end
      s_r    <= sraw_r[55:16];
      posd_r <= posc_r;

      pe_r <= pd_r;
      for (int i = 0; i < 3; i++) begin
        f_r[i]  <= 57'($signed({1'b0, fric_r})) * 57'(ut_r[i]);
        nr_r[i] <= posd_r ? 58'(s_r) * 58'(nd_r[i]) : '0;
      end

      // Select the action for the face type and mode.
      if (!pe_r.wall) begin
        out_user_r <= 2'b10;
        out_data_r <= pe_r.vel;
      end else begin
        case (mode_r)
          wpvc_pkg::MODE_ESCAPE: begin
            out_user_r <= 2'b01;
            out_data_r <= '0;
          end
          wpvc_pkg::MODE_STICK: begin
            out_user_r <= 2'b11;
            out_data_r <= '0;
          end
          default: begin
            out_user_r <= 2'b11;
            out_data_r <= reb_data;
          end
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

@@ rtl/wpvc_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on wpvc_pkg for the stage count.
`default_nettype none

module wpvc_sqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] val_i,
  output logic      [31:0] root_o
);

  logic [34:0] rem_r  [0:wpvc_pkg::SQ_STEPS-1];
  logic [31:0] root_r [0:wpvc_pkg::SQ_STEPS-1];
  logic [63:0] val_r  [0:wpvc_pkg::SQ_STEPS-1];

  logic [34:0] rem_nxt  [0:wpvc_pkg::SQ_STEPS-1];
  logic [31:0] root_nxt [0:wpvc_pkg::SQ_STEPS-1];
  logic [63:0] val_nxt  [0:wpvc_pkg::SQ_STEPS-1];

  always_comb begin
    logic [34:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] v_in;
    logic [34:0] rem_t;
    logic [34:0] trial;
    for (int k = 0; k < wpvc_pkg::SQ_STEPS; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        v_in    = val_i;
      end else begin
        rem_in  = rem_r[k-1];
        root_in = root_r[k-1];
        v_in    = val_r[k-1];
      end
      rem_t = {rem_in[32:0], v_in[63:62]};
      trial = {1'b0, root_in, 2'b01};
      if (rem_t >= trial) begin
        rem_nxt[k]  = rem_t - trial;
        root_nxt[k] = {root_in[30:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_t;
        root_nxt[k] = {root_in[30:0], 1'b0};
      end
      val_nxt[k] = {v_in[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < wpvc_pkg::SQ_STEPS; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        val_r[k]  <= val_nxt[k];
      end
    end
  end

  assign root_o = root_r[wpvc_pkg::SQ_STEPS-1];

endmodule

`default_nettype wire

@@ rtl/wpvc_div.sv @@
// Pipelined restoring divider for the unit normal: 48-bit dividend, 32-bit
// divisor, 17-bit quotient, one quotient bit per stage. Depends on wpvc_pkg.
`default_nettype none

module wpvc_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [47:0] num_i,
  input  wire logic [31:0] den_i,
  output logic      [16:0] quo_o
);

  logic [31:0] rem_r [0:wpvc_pkg::DIV_STEPS-1];
  logic [31:0] den_r [0:wpvc_pkg::DIV_STEPS-1];
  logic [16:0] low_r [0:wpvc_pkg::DIV_STEPS-1];
  logic [16:0] quo_r [0:wpvc_pkg::DIV_STEPS-1];

  logic [31:0] rem_nxt [0:wpvc_pkg::DIV_STEPS-1];
  logic [16:0] low_nxt [0:wpvc_pkg::DIV_STEPS-1];
  logic [16:0] quo_nxt [0:wpvc_pkg::DIV_STEPS-1];

  // The quotient is known to stay below 2^17, so the upper dividend bits
  // already form a partial remainder below the divisor.
  always_comb begin
    logic [31:0] rem_in;
    logic [31:0] d_in;
    logic [16:0] low_in;
    logic [16:0] q_in;
    logic [32:0] rem_t;
    for (int k = 0; k < wpvc_pkg::DIV_STEPS; k++) begin
      if (k == 0) begin
        rem_in = {1'b0, num_i[47:17]};
        d_in   = den_i;
        low_in = num_i[16:0];
        q_in   = '0;
      end else begin
        rem_in = rem_r[k-1];
        d_in   = den_r[k-1];
        low_in = low_r[k-1];
        q_in   = quo_r[k-1];
      end
      rem_t = {rem_in, low_in[16]};
      if (rem_t >= {1'b0, d_in}) begin
        rem_nxt[k] = 32'(rem_t - {1'b0, d_in});
        quo_nxt[k] = {q_in[15:0], 1'b1};
      end else begin
        rem_nxt[k] = rem_t[31:0];
        quo_nxt[k] = {q_in[15:0], 1'b0};
      end
      low_nxt[k] = {low_in[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den_i;
      for (int k = 0; k < wpvc_pkg::DIV_STEPS; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
      for (int k = 1; k < wpvc_pkg::DIV_STEPS; k++) begin
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign quo_o = quo_r[wpvc_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire
